/* rtl/dcrc_pkg.sv */
// Package for the dirty chunk run coalescer: payload structs, register indexes,
// arithmetic widths and the command/status types between controller and datapath.
// No dependencies.
package dcrc_pkg;

  // configuration register widths and port width
  localparam int CB_W       = 17;
  localparam int LIM_W      = 32;
  localparam int RATE_W     = 24;
  localparam int SETUP_W    = 40;
  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;

  // result field widths
  localparam int OUT_START_W  = 10;
  localparam int OUT_CHUNKS_W = 11;

  // shared multiplier: 41 x 17 bits, 58 bit product
  localparam int MUL_A_W    = 41;
  localparam int MUL_B_W    = 17;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int BYTES_W    = 34;
  localparam int NEW_COST_W = 42;

  // register reset values
  localparam logic [CB_W-1:0]    CB_RST    = 17'd4096;
  localparam logic [LIM_W-1:0]   TIER1_RST = 32'd16384;
  localparam logic [LIM_W-1:0]   TIER2_RST = 32'd262144;
  localparam logic [RATE_W-1:0]  RATE_RST  = 24'd65536;
  localparam logic [SETUP_W-1:0] SETUP_RST = 40'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHUNK_BYTES = 3'd0,
    CFG_TIER1_LIMIT = 3'd1,
    CFG_TIER2_LIMIT = 3'd2,
    CFG_RATE_TIER1  = 3'd3,
    CFG_RATE_TIER2  = 3'd4,
    CFG_RATE_MEMORY = 3'd5,
    CFG_SETUP_COST  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic chunk_dirty;
    logic chunk_last;
  } in_item_t;

  typedef struct packed {
    logic                    has_transfer;
    logic [OUT_START_W-1:0]  transfer_start;
    logic [OUT_CHUNKS_W-1:0] transfer_chunks;
    logic                    block_done;
  } out_item_t;

  // operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_SPAN = 2'd0,  // span * chunk_bytes
    MUL_NEW  = 2'd1,  // rate(1) * chunk_bytes
    MUL_RATE = 2'd2,  // rate(span) * (gaps + 1)
    MUL_GAP  = 2'd3   // previous product * chunk_bytes
  } mul_op_t;

  typedef struct packed {
    logic    load_item;
    logic    mul_en;
    mul_op_t mul_op;
    logic    commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_cost;
    logic has_result;
  } dp_status_t;

endpackage

/* rtl/dirty_chunk_run_coalescer.sv */
// Top level of the dirty chunk run coalescer: controller plus datapath.
// Depends on dcrc_pkg, dcrc_ctrl and dcrc_dp.

// Takes one chunk dirty bit per input transaction and merges dirty chunks into
// transfer descriptors, absorbing clean chunks as gaps while the tiered gap cost
// stays below the cost of a new transfer. One chunk is processed at a time. A
// dirty chunk, or any chunk with no run open, is captured and then committed. A
// clean chunk inside an open run makes four passes through the single shared
// 41x17 bit cost multiplier between capture and commit. The next chunk is
// accepted in the cycle after the commit, even while the previous result is
// still waiting in the output register. The commit itself waits while that
// register is still held by a stalled transaction, whether or not the chunk
// produces a result. Configuration must be written while no chunk is in
// flight.
module dirty_chunk_run_coalescer #(
  parameter int MAX_CHUNKS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dcrc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dcrc_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [dcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcrc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dcrc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dcrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  dcrc_dp #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data)
  );

endmodule

/* rtl/dcrc_dp.sv */
// Datapath of the run coalescer: configuration registers, run state, shared
// cost multiplier and the result register.
// Depends on dcrc_pkg.
module dcrc_dp #(
  parameter int MAX_CHUNKS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dcrc_pkg::dp_cmd_t              cmd,
  output dcrc_pkg::dp_status_t           status,
  input  logic                           cfg_we,
  input  logic [dcrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  dcrc_pkg::in_item_t             in_data,
  output dcrc_pkg::out_item_t            out_data
);
  import dcrc_pkg::*;

  localparam int POS_W  = $clog2(MAX_CHUNKS);
  localparam int SPAN_W = POS_W + 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_CHUNKS - 1);

  logic [CB_W-1:0]    cb_r;
  logic [LIM_W-1:0]   tier1_r, tier2_r;
  logic [RATE_W-1:0]  rate1_r, rate2_r, ratem_r;
  logic [SETUP_W-1:0] setup_r;

  logic              run_open_r;
  logic [POS_W-1:0]  first_r, final_r, pos_r;
  logic [SPAN_W-1:0] gap_r;
  logic              dirty_r, last_r;

  logic [PROD_W-1:0]     prod_r;
  logic [RATE_W-1:0]     rate_n_r;
  logic [NEW_COST_W-1:0] new_cost_r;
  out_item_t             out_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [SPAN_W-1:0]  span, gapp1, chunks;
  logic [RATE_W-1:0]  rate_one, rate_span;
  logic               gap_less, last;

  logic              open_nxt, emit;
  logic [POS_W-1:0]  first_nxt, final_nxt, pos_nxt;
  logic [SPAN_W-1:0] gap_nxt;
  out_item_t         out_nxt;

  function automatic logic [RATE_W-1:0] tier_rate(
    input logic [BYTES_W-1:0] bytes,
    input logic [LIM_W-1:0]   lim1,
    input logic [LIM_W-1:0]   lim2,
    input logic [RATE_W-1:0]  r1,
    input logic [RATE_W-1:0]  r2,
    input logic [RATE_W-1:0]  rm
  );
    logic [RATE_W-1:0] r;
    if (bytes <= BYTES_W'(lim1)) begin
      r = r1;
    end else if (bytes <= BYTES_W'(lim2)) begin
      r = r2;
    end else begin
      r = rm;
    end
    return r;
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_r    <= CB_RST;
      tier1_r <= TIER1_RST;
      tier2_r <= TIER2_RST;
      rate1_r <= RATE_RST;
      rate2_r <= RATE_RST;
      ratem_r <= RATE_RST;
      setup_r <= SETUP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHUNK_BYTES: cb_r    <= cfg_wdata[CB_W-1:0];
        CFG_TIER1_LIMIT: tier1_r <= cfg_wdata[LIM_W-1:0];
        CFG_TIER2_LIMIT: tier2_r <= cfg_wdata[LIM_W-1:0];
        CFG_RATE_TIER1:  rate1_r <= cfg_wdata[RATE_W-1:0];
        CFG_RATE_TIER2:  rate2_r <= cfg_wdata[RATE_W-1:0];
        CFG_RATE_MEMORY: ratem_r <= cfg_wdata[RATE_W-1:0];
        CFG_SETUP_COST:  setup_r <= cfg_wdata[SETUP_W-1:0];
        default: ;
      endcase
    end
  end

  assign span      = SPAN_W'(pos_r) - SPAN_W'(first_r) + SPAN_W'(1);
  assign gapp1     = gap_r + SPAN_W'(1);
  assign rate_one  = tier_rate(BYTES_W'(cb_r), tier1_r, tier2_r, rate1_r, rate2_r, ratem_r);
  // prod_r holds span * chunk_bytes when this is sampled
  assign rate_span = tier_rate(prod_r[BYTES_W-1:0], tier1_r, tier2_r,
                               rate1_r, rate2_r, ratem_r);

  always_comb begin
    unique case (cmd.mul_op)
      MUL_SPAN: begin
        mul_a = MUL_A_W'(span);
        mul_b = cb_r;
      end
      MUL_NEW: begin
        mul_a = MUL_A_W'(rate_one);
        mul_b = cb_r;
      end
      MUL_RATE: begin
        mul_a = MUL_A_W'(rate_n_r);
        mul_b = MUL_B_W'(gapp1);
      end
      MUL_GAP: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = cb_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_p;
      if (cmd.mul_op == MUL_NEW) begin
        rate_n_r <= rate_span;
      end
      if (cmd.mul_op == MUL_RATE) begin
        new_cost_r <= NEW_COST_W'(setup_r) + NEW_COST_W'(prod_r[MUL_A_W-1:0]);
      end
    end
    if (cmd.load_item) begin
      dirty_r <= in_data.chunk_dirty;
      last_r  <= in_data.chunk_last;
    end
  end

  // gap cost sits in prod_r after the last multiply pass
  assign gap_less = prod_r < PROD_W'(new_cost_r);
  assign last     = last_r || (pos_r >= POS_LAST);

  always_comb begin
    open_nxt  = run_open_r;
    first_nxt = first_r;
    final_nxt = final_r;
    gap_nxt   = gap_r;
    emit      = 1'b0;
    if (run_open_r) begin
      if (dirty_r) begin
        final_nxt = pos_r;
      end else if (gap_less) begin
        gap_nxt = gapp1;
      end else begin
        open_nxt = 1'b0;
        emit     = 1'b1;
      end
    end else if (dirty_r) begin
      open_nxt  = 1'b1;
      first_nxt = pos_r;
      final_nxt = pos_r;
      gap_nxt   = '0;
    end
    if (last && open_nxt) begin
      emit = 1'b1;
    end
    chunks = SPAN_W'(final_nxt) - SPAN_W'(first_nxt) + SPAN_W'(1);
    if (last) begin
      open_nxt = 1'b0;
      gap_nxt  = '0;
      pos_nxt  = '0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
    out_nxt.has_transfer    = emit;
    out_nxt.transfer_start  = emit ? OUT_START_W'(first_nxt) : '0;
    out_nxt.transfer_chunks = emit ? OUT_CHUNKS_W'(chunks) : '0;
    out_nxt.block_done      = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r <= 1'b0;
      first_r    <= '0;
      final_r    <= '0;
      gap_r      <= '0;
      pos_r      <= '0;
    end else if (cmd.commit) begin
      run_open_r <= open_nxt;
      first_r    <= first_nxt;
      final_r    <= final_nxt;
      gap_r      <= gap_nxt;
      pos_r      <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && (emit || last)) begin
      out_r <= out_nxt;
    end
  end

  assign status.need_cost  = run_open_r && !in_data.chunk_dirty;
  assign status.has_result = emit || last;
  assign out_data          = out_r;

endmodule

/* rtl/dcrc_ctrl.sv */
// Controller of the run coalescer: sequences item capture, the four cost
// multiply passes and the commit, and owns both handshakes.
// Depends on dcrc_pkg.
module dcrc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dcrc_pkg::dp_cmd_t    cmd,
  input  dcrc_pkg::dp_status_t status
);
  import dcrc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_NEWC,
    S_RATE,
    S_GAP,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = status.need_cost ? S_SPAN : S_COMMIT;
        end
      end
      S_SPAN:  state_nxt = S_NEWC;
      S_NEWC:  state_nxt = S_RATE;
      S_RATE:  state_nxt = S_GAP;
      S_GAP:   state_nxt = S_COMMIT;
      S_COMMIT: begin
        // hold until the result register can take a new transaction
        if (out_free) begin
          out_valid_nxt = status.has_result;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load_item = (state_r == S_IDLE) && in_valid;
    cmd.commit    = (state_r == S_COMMIT) && out_free;
    cmd.mul_en    = 1'b1;
    unique case (state_r)
      S_SPAN:  cmd.mul_op = MUL_SPAN;
      S_NEWC:  cmd.mul_op = MUL_NEW;
      S_RATE:  cmd.mul_op = MUL_RATE;
      S_GAP:   cmd.mul_op = MUL_GAP;
      default: begin
        cmd.mul_op = MUL_SPAN;
        cmd.mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/dcrc_checker.sv */
// Port-level checks for the run coalescer, bound to the top level.
// Depends on dcrc_pkg and dirty_chunk_run_coalescer.
module dcrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input dcrc_pkg::out_item_t out_data
);
  import dcrc_pkg::*;

  // a held result transaction keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one chunk at a time: busy right after an accepted chunk
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("chunk accepted with another in flight");

  // a result only appears as the commit of a chunk in flight
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a chunk in flight");

  // an empty result is only the end-of-block marker
  a_empty_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_transfer |->
      out_data.block_done && (out_data.transfer_start == '0) &&
      (out_data.transfer_chunks == '0))
    else $error("empty result is not a block end marker");

endmodule

bind dirty_chunk_run_coalescer dcrc_checker u_dcrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* sim/dirty_chunk_run_coalescer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for dirty_chunk_run_coalescer: scoreboard class with its own
// cost and run predictor, driver tasks for the chunk and register ports and a
// descriptor receiver. Depends on dcrc_pkg and the RTL of the block.
module dirty_chunk_run_coalescer_tb;
  import dcrc_pkg::*;

  localparam int MAX_CHUNKS   = 1024;
  localparam int IDLE_MAX     = 9;
  localparam int IDLE_CYCLES  = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 650;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TIMEOUT_NS   = 2000000;
  localparam int RATE_MAX     = (1 << RATE_W) - 1;

  localparam logic [CB_W-1:0]      CB_MAX        = 17'd65536;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  class run_descriptor_scoreboard #(parameter int MAX_CHUNKS = 1024);
    logic [CB_W-1:0]         chunk_size;
    logic [LIM_W-1:0]        l1_bound, l2_bound;
    logic [RATE_W-1:0]       l1_rate, l2_rate, mem_rate;
    logic [SETUP_W-1:0]      xfer_setup;
    logic                    run_active;
    logic [OUT_START_W-1:0]  run_head, run_tail, next_chunk;
    logic [OUT_CHUNKS_W-1:0] gaps_held;
    out_item_t               pending_descriptors[$];
    int failures, results_seen, transfers_seen, gaps_absorbed, blocks_seen;

    function new();
      chunk_size = CB_RST;
      l1_bound   = TIER1_RST;
      l2_bound   = TIER2_RST;
      l1_rate    = RATE_RST;
      l2_rate    = RATE_RST;
      mem_rate   = RATE_RST;
      xfer_setup = SETUP_RST;
      run_active = 1'b0;
      run_head   = '0;
      run_tail   = '0;
      next_chunk = '0;
      gaps_held  = '0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CHUNK_BYTES: chunk_size = data[CB_W-1:0];
        CFG_TIER1_LIMIT: l1_bound = data[LIM_W-1:0];
        CFG_TIER2_LIMIT: l2_bound = data[LIM_W-1:0];
        CFG_RATE_TIER1:  l1_rate = data[RATE_W-1:0];
        CFG_RATE_TIER2:  l2_rate = data[RATE_W-1:0];
        CFG_RATE_MEMORY: mem_rate = data[RATE_W-1:0];
        CFG_SETUP_COST:  xfer_setup = data[SETUP_W-1:0];
        default: ;
      endcase
    endfunction

    // per-byte rate picked by the byte size of a span of chunks
    function logic [63:0] byte_rate(logic [63:0] span);
      logic [63:0] bytes;
      bytes = span * chunk_size;
      if (bytes <= l1_bound) return l1_rate;
      if (bytes <= l2_bound) return l2_rate;
      return mem_rate;
    endfunction

    function void predict_chunk(in_item_t item);
      logic [63:0]             span, gap_cost, new_cost;
      logic [OUT_START_W-1:0]  pos, t_start;
      logic [OUT_CHUNKS_W-1:0] t_chunks;
      logic                    is_last, emit;
      out_item_t               want;
      pos      = next_chunk;
      is_last  = item.chunk_last || (int'(next_chunk) >= MAX_CHUNKS - 1);
      emit     = 1'b0;
      t_start  = '0;
      t_chunks = '0;
      if (run_active) begin
        if (item.chunk_dirty) begin
          run_tail = pos;
        end else begin
          span = pos;
          span = span - run_head + 64'd1;
          gap_cost = byte_rate(span) * (gaps_held + 64'd1) * chunk_size;
          new_cost = xfer_setup + byte_rate(64'd1) * chunk_size;
          if (gap_cost < new_cost) begin
            gaps_held++;
            gaps_absorbed++;
          end else begin
            run_active = 1'b0;
            emit       = 1'b1;
            t_start    = run_head;
            t_chunks   = OUT_CHUNKS_W'(run_tail) - OUT_CHUNKS_W'(run_head) +
                         OUT_CHUNKS_W'(1);
          end
        end
      end else if (item.chunk_dirty) begin
        run_active = 1'b1;
        run_head   = pos;
        run_tail   = pos;
        gaps_held  = '0;
      end
      // an open run is flushed at the block end, trailing gaps not counted
      if (is_last && run_active) begin
        emit     = 1'b1;
        t_start  = run_head;
        t_chunks = OUT_CHUNKS_W'(run_tail) - OUT_CHUNKS_W'(run_head) + OUT_CHUNKS_W'(1);
      end
      if (is_last) begin
        run_active = 1'b0;
        gaps_held  = '0;
        next_chunk = '0;
        blocks_seen++;
      end else begin
        next_chunk = pos + 1'b1;
      end
      if (emit || is_last) begin
        want = '{has_transfer: emit, transfer_start: t_start, transfer_chunks: t_chunks,
                 block_done: is_last};
        pending_descriptors = {pending_descriptors, want};
      end
    endfunction

    function string show(out_item_t d);
      return $sformatf("transfer %0b start %0d chunks %0d done %0b",
                       d.has_transfer, d.transfer_start, d.transfer_chunks, d.block_done);
    endfunction

    function void log_failure(string msg);
      failures++;
      if (failures <= 10) $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function void check_descriptor(out_item_t seen);
      out_item_t want;
      results_seen++;
      if (seen.has_transfer) transfers_seen++;
      if (pending_descriptors.size() == 0) begin
        log_failure({"unexpected descriptor: ", show(seen)});
        return;
      end
      want = pending_descriptors.pop_front();
      if (seen.has_transfer !== want.has_transfer ||
          seen.transfer_start !== want.transfer_start ||
          seen.transfer_chunks !== want.transfer_chunks ||
          seen.block_done !== want.block_done) begin
        log_failure({"expected ", show(want), ", got ", show(seen)});
      end
    endfunction

    function int pending();
      return pending_descriptors.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  run_descriptor_scoreboard #(MAX_CHUNKS) descr_sb;
  int tx_max, rx_max, rx_hold;
  int chunks_sent, cost_settings;

  dirty_chunk_run_coalescer #(.MAX_CHUNKS(MAX_CHUNKS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) descr_sb.check_descriptor(out_data);
  end

  // all tasks start and end on a falling edge
  task automatic send_chunk(input logic dirty, input logic last);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{chunk_dirty: dirty, chunk_last: last};
    do @(posedge clk); while (in_stall);
    descr_sb.predict_chunk(in_data);
    chunks_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_block(input int len);
    int density;
    density = $urandom_range(0, 100);
    for (int i = 0; i < len; i++) begin
      send_chunk($urandom_range(1, 100) <= density, i == len - 1);
    end
  endtask

  // wait until every expected descriptor is out and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (descr_sb.pending() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cost_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    descr_sb.apply_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic load_costs(input logic [CB_W-1:0] cb, input logic [LIM_W-1:0] l1,
                            input logic [LIM_W-1:0] l2, input logic [RATE_W-1:0] r1,
                            input logic [RATE_W-1:0] r2, input logic [RATE_W-1:0] rm,
                            input logic [SETUP_W-1:0] setup);
    settle();
    write_cost_reg(CFG_CHUNK_BYTES, CFG_DATA_W'(cb));
    write_cost_reg(CFG_TIER1_LIMIT, CFG_DATA_W'(l1));
    write_cost_reg(CFG_TIER2_LIMIT, CFG_DATA_W'(l2));
    write_cost_reg(CFG_RATE_TIER1, CFG_DATA_W'(r1));
    write_cost_reg(CFG_RATE_TIER2, CFG_DATA_W'(r2));
    write_cost_reg(CFG_RATE_MEMORY, CFG_DATA_W'(rm));
    write_cost_reg(CFG_SETUP_COST, CFG_DATA_W'(setup));
    cfg_we <= 1'b0;
    cost_settings++;
  endtask

  // tier bounds on chunk multiples and a setup cost near a few gap costs
  task automatic random_costs();
    logic [CB_W-1:0]   cb;
    logic [LIM_W-1:0]  l1, l2;
    logic [RATE_W-1:0] r1, r2, rm;
    logic [63:0]       setup;
    case ($urandom_range(0, 7))
      0: cb = '0;
      1: cb = 17'd1;
      2: cb = CB_MAX;
      3: cb = CB_RST;
      default: cb = CB_W'($urandom_range(1, CB_MAX));
    endcase
    l1 = cb * $urandom_range(0, 8);
    l2 = l1 + cb * $urandom_range(0, 24);
    if ($urandom_range(0, 5) == 0) l1 = $urandom;
    if ($urandom_range(0, 5) == 0) l2 = $urandom;
    r1 = RATE_W'($urandom_range(0, RATE_MAX));
    r2 = RATE_W'($urandom_range(0, RATE_MAX));
    rm = RATE_W'($urandom_range(0, RATE_MAX));
    setup = r1;
    setup = setup * cb * $urandom_range(0, 4) + $urandom_range(0, 1023);
    if ($urandom_range(0, 5) == 0) setup = {$urandom, $urandom};
    load_costs(cb, l1, l2, r1, r2, rm, setup[SETUP_W-1:0]);
  endtask

  // descriptor receiver with random stalls and an occasional long hold-off
  initial begin
    int pause;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      pause = $urandom_range(0, rx_max);
      if (rx_hold > 0) begin
        pause   = rx_hold;
        rx_hold = 0;
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int target;
    int phase_end;
    int round;
    descr_sb  = new();
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    tx_max    = IDLE_MAX;
    rx_max    = IDLE_MAX;
    rx_hold   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // unused register index must leave the reset costs alone
    write_cost_reg(CFG_IDX_SPARE, CFG_DATA_W'({$urandom, $urandom}));
    cfg_we <= 1'b0;
    @(negedge clk);

    // one-chunk blocks, clean and dirty
    send_chunk(1'b0, 1'b1);
    send_chunk(1'b1, 1'b1);
    // reset costs absorb one gap, a second clean chunk closes the run,
    // then a fresh run later in the block must report its own length
    send_chunk(1'b1, 1'b0);
    send_chunk(1'b0, 1'b0);
    send_chunk(1'b1, 1'b0);
    send_chunk(1'b0, 1'b0);
    send_chunk(1'b0, 1'b0);
    send_chunk(1'b1, 1'b0);
    send_chunk(1'b0, 1'b0);
    send_chunk(1'b0, 1'b1);
    // run still open on a trailing gap at the block end
    send_chunk(1'b0, 1'b0);
    send_chunk(1'b1, 1'b0);
    send_chunk(1'b0, 1'b1);
    // clean block
    send_chunk(1'b0, 1'b0);
    send_chunk(1'b0, 1'b0);
    send_chunk(1'b0, 1'b1);

    // overlong all-dirty block: the final position ends it without a last flag
    settle();
    tx_max = 0;
    rx_max = 0;
    repeat (MAX_CHUNKS) send_chunk(1'b1, 1'b0);
    send_random_block(5);

    tx_max = IDLE_MAX;
    rx_max = IDLE_MAX;
    // zero chunk size and zero setup: every clean chunk closes a run
    load_costs('0, '0, '0, '0, '0, '0, '0);
    repeat (4) send_random_block($urandom_range(1, 24));
    // zero chunk size with top setup cost: gaps always absorbed
    load_costs('0, '1, '1, '1, '1, '1, '1);
    repeat (4) send_random_block($urandom_range(1, 24));
    // single-byte chunks, everything past the tiers at top rate
    load_costs(17'd1, '0, '0, '0, '0, '1, '0);
    repeat (4) send_random_block($urandom_range(1, 24));
    // every register at its top value, the chunk size at CB_MAX
    load_costs(CB_MAX, '1, '1, '1, '1, '1, '1);
    repeat (4) send_random_block($urandom_range(1, 24));
    // tiers at two and four chunks so the gap budget shrinks as the run grows
    load_costs(CB_RST, 32'd8192, 32'd16384, 24'd1, RATE_RST, RATE_W'(RATE_MAX),
               40'h20000000);
    repeat (4) send_random_block($urandom_range(1, 24));

    target = chunks_sent + RANDOM_ITEMS;
    round  = 0;
    while (chunks_sent < target) begin
      random_costs();
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
      if (round == 0) begin
        // long block so that later chunk positions start transfers
        send_random_block($urandom_range(150, 400));
        settle();
      end else if (round == 1) begin
        // receiver holds off while chunks keep coming, input must back up
        tx_max  = 0;
        rx_hold = HOLD_CYCLES;
      end
      phase_end = chunks_sent + PHASE_ITEMS;
      while (chunks_sent < phase_end) begin
        send_random_block(($urandom_range(0, 24) == 0) ? $urandom_range(40, 200)
                                                        : $urandom_range(1, 20));
        if ($urandom_range(0, 7) == 0) settle();
      end
      round++;
    end

    in_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && descr_sb.pending() != 0; n++) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
    if (descr_sb.pending() != 0) begin
      descr_sb.log_failure($sformatf("%0d descriptors never arrived", descr_sb.pending()));
    end

    $display("covered %0d chunks in %0d blocks over %0d cost settings, one block overlong",
             chunks_sent, descr_sb.blocks_seen, cost_settings);
    $display("%0d descriptors checked, %0d transfers, %0d gaps absorbed, %0d failures",
             descr_sb.results_seen, descr_sb.transfers_seen, descr_sb.gaps_absorbed,
             descr_sb.failures);
    if (descr_sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
